FILE: rtl/csrb_pkg.sv
// Package for the comparator status register block.
// Holds the register map, the event codes and the flag bit positions.
// No dependencies.
package csrb_pkg;

  // Storage size; offsets past the 4-bit index range are never reached
  localparam int REG_WORDS = 16;
  localparam int REG_IDX_W = 4;
  localparam int REG_DEPTH = (REG_WORDS < (1 << REG_IDX_W)) ? REG_WORDS : (1 << REG_IDX_W);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [31:0]          word_t;
  typedef logic [1:0]           opcode_t;

  // Event codes
  localparam opcode_t OP_READ  = 2'd0;
  localparam opcode_t OP_WRITE = 2'd1;
  localparam opcode_t OP_LEVEL = 2'd2;
  localparam opcode_t OP_TRIG  = 2'd3;

  // Word offsets
  localparam reg_idx_t W_VERID = 4'd0;
  localparam reg_idx_t W_PARAM = 4'd1;
  localparam reg_idx_t W_CTRL0 = 4'd2;
  localparam reg_idx_t W_CTRL1 = 4'd3;
  localparam reg_idx_t W_IER   = 4'd7;
  localparam reg_idx_t W_CSR   = 4'd8;
  localparam reg_idx_t W_RRCR0 = 4'd9;
  localparam reg_idx_t W_RRCSR = 4'd11;

  // Fixed values
  localparam word_t VERID_VALUE = 32'h0100_0041;
  localparam word_t PARAM_VALUE = 32'h0000_0002;
  localparam word_t CTRL0_RESET = 32'h0000_0002;

  // Bit positions
  localparam int FLAG_RISE_BIT = 0;
  localparam int FLAG_FALL_BIT = 1;
  localparam int FLAG_RR_BIT   = 2;
  localparam int CSR_OUT_BIT   = 8;
  localparam int DMA_EN_BIT    = 2;
  localparam int RR_EN_BIT     = 0;
  localparam int RR_TIMER_BIT  = 1;
  localparam word_t FLAG_MASK  = 32'h0000_0007;

endpackage

FILE: rtl/comparator_status_register_block.sv
// Comparator status register block: register file, edge/round-robin flags,
// irq level and DMA pulse generation. Depends on csrb_pkg.
// The result of an accepted input is registered in the output register.
// Throughput: one transaction per cycle; the single output register is refilled
// in the same cycle it drains, so input stall follows output stall only when full.
// Reset (rst_n, synchronous, active low): registers zero except control 0 = 2,
// output level and baseline 0, output register empty.
module comparator_status_register_block
  import csrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_level,
  output logic        out_dma_pulse
);

  word_t rf_r   [REG_DEPTH];
  word_t rf_nxt [REG_DEPTH];
  logic  level_r, level_nxt;
  logic  base_r, base_nxt;

  logic  out_valid_r;
  word_t out_read_data_r, rdata_nxt;
  logic  out_irq_r, irq_nxt;
  logic  out_dma_r, dma_nxt;

  logic  in_accept;
  logic  idx_ok;
  logic  bit0;
  logic  rise, fall;
  word_t csr_cur, ier_cur, rr_cur;

  // Handshake: accept whenever the output register is empty or draining
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign idx_ok  = ({1'b0, in_reg_index} < (REG_IDX_W+1)'(REG_DEPTH));
  assign bit0    = in_data_in[0];
  assign csr_cur = rf_r[W_CSR];
  assign ier_cur = rf_r[W_IER];
  assign rr_cur  = rf_r[W_RRCR0];
  assign rise    = bit0 & ~level_r;
  assign fall    = ~bit0 & level_r;

  // Read mux
  always_comb begin
    rdata_nxt = '0;
    if (in_opcode == OP_READ) begin
      case (in_reg_index)
        W_VERID: rdata_nxt = VERID_VALUE;
        W_PARAM: rdata_nxt = PARAM_VALUE;
        W_CSR: begin
          rdata_nxt = csr_cur;
          rdata_nxt[CSR_OUT_BIT] = level_r;
        end
        default: rdata_nxt = idx_ok ? rf_r[in_reg_index] : '0;
      endcase
    end
  end

  // State update for one event
  always_comb begin
    rf_nxt    = rf_r;
    level_nxt = level_r;
    base_nxt  = base_r;
    dma_nxt   = 1'b0;
    unique case (in_opcode)
      OP_READ: begin
      end
      OP_WRITE: begin
        if (in_reg_index == W_VERID || in_reg_index == W_PARAM) begin
          // read-only ID words
        end else if (in_reg_index == W_CSR) begin
          rf_nxt[W_CSR] = csr_cur & ~(in_data_in & FLAG_MASK);
        end else if (in_reg_index == W_RRCR0) begin
          rf_nxt[W_RRCR0] = in_data_in;
          if (in_data_in[RR_EN_BIT] && !rr_cur[RR_EN_BIT]) begin
            base_nxt = level_r;
          end
        end else if (idx_ok) begin
          rf_nxt[in_reg_index] = in_data_in;
        end
      end
      OP_LEVEL: begin
        if (rise) begin
          rf_nxt[W_CSR][FLAG_RISE_BIT] = 1'b1;
          dma_nxt = rf_r[W_CTRL1][DMA_EN_BIT] & ier_cur[FLAG_RISE_BIT];
        end else if (fall) begin
          rf_nxt[W_CSR][FLAG_FALL_BIT] = 1'b1;
          dma_nxt = rf_r[W_CTRL1][DMA_EN_BIT] & ier_cur[FLAG_FALL_BIT];
        end
        level_nxt = bit0;
      end
      OP_TRIG: begin
        if (bit0 && rr_cur[RR_EN_BIT] && !rr_cur[RR_TIMER_BIT]) begin
          rf_nxt[W_RRCSR][0] = level_r;
          if (level_r != base_r) begin
            rf_nxt[W_CSR][FLAG_RR_BIT] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Irq level from the state after the event
  assign irq_nxt = ~rf_nxt[W_CTRL1][DMA_EN_BIT]
                 & (|(rf_nxt[W_CSR] & rf_nxt[W_IER] & FLAG_MASK));

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_DEPTH; i++) begin
        rf_r[i] <= (i == int'(W_CTRL0)) ? CTRL0_RESET : '0;
      end
      level_r       <= 1'b0;
      base_r        <= 1'b0;
    end else if (in_accept) begin
      rf_r    <= rf_nxt;
      level_r <= level_nxt;
      base_r  <= base_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_data_r <= rdata_nxt;
      out_irq_r       <= irq_nxt;
      out_dma_r       <= dma_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_level = out_irq_r;
  assign out_dma_pulse = out_dma_r;

  // DMA pulse needs the DMA enable, which masks the irq
  a_dma_masks_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dma_r |-> !out_irq_r)
    else $error("dma pulse with irq asserted");

  // Non-read transactions return zero data
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_opcode != OP_READ |=> out_read_data_r == '0)
    else $error("non-read returned data");

  // A status write only clears flags
  a_csr_w1c: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_opcode == OP_WRITE && in_reg_index == W_CSR |=>
      (rf_r[W_CSR][2:0] & ~$past(rf_r[W_CSR][2:0])) == 3'b000)
    else $error("status write set a flag");

  // Unchanged level sets no edge flag
  a_same_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_opcode == OP_LEVEL && in_data_in[0] == level_r |=>
      rf_r[W_CSR][1:0] == $past(rf_r[W_CSR][1:0]))
    else $error("edge flag without an edge");

endmodule
